/* hw/rtl/rrss_pkg.sv */
// Package for the round-robin slice scheduler: payload structs, request and result codes,
// sequencer states and the control and status structs shared by the sequencer and datapath.
// No dependencies.
package rrss_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int BURST_W      = 16;
  localparam int TIME_W       = 20;
  localparam int JOB_IDX_W    = 4;

  localparam logic [BURST_W-1:0] QUANTUM_RST = 16'd4;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SLICE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] KIND_LOADED = 2'd0;
  localparam logic [1:0] KIND_SLICE  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [BURST_W-1:0] burst;
  } req_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    slice_end_time;
    logic                 job_finished;
    logic [TIME_W-1:0]    waiting_time;
    logic                 all_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_ADD,
    ST_FIN
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [1:0] {
    SEL_REM_QUANTUM,
    SEL_TIME_RUN,
    SEL_TIME_ORIG
  } alu_sel_t;

  typedef struct packed {
    logic full;
    logic no_work;
    logic rem_zero;
  } seq_stat_t;

  typedef struct packed {
    logic     busy;
    logic     ld_ok;
    logic     ld_full;
    logic     clr;
    logic     nop;
    logic     slice_go;
    logic     rd;
    logic     skip;
    logic     sub_q;
    logic     add;
    logic     fin;
    alu_op_t  alu_op;
    alu_sel_t alu_sel;
  } seq_ctrl_t;

endpackage

/* hw/rtl/rrss_burst_ram.sv */
// Burst store of the round-robin slice scheduler: one write port, one registered read port.
// Depends on nothing; sized by its parameters.
module rrss_burst_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/rrss_alu.sv */
// Shared add and subtract unit of the round-robin slice scheduler.
// Depends on rrss_pkg for the operation codes and widths.
module rrss_alu (
  input  rrss_pkg::alu_op_t               op,
  input  logic [rrss_pkg::TIME_W-1:0]     a,
  input  logic [rrss_pkg::TIME_W-1:0]     b,
  output logic [rrss_pkg::TIME_W-1:0]     res,
  output logic                            borrow
);

  logic [rrss_pkg::TIME_W:0] full;

  always_comb begin
    case (op)
      rrss_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      rrss_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      default:           full = {1'b0, a} + {1'b0, b};
    endcase
  end

  assign res    = full[rrss_pkg::TIME_W-1:0];
  assign borrow = full[rrss_pkg::TIME_W];

endmodule

/* hw/rtl/rrss_seq.sv */
// Sequencer of the round-robin slice scheduler: decodes transactions and steps a slice
// through read, scan, time update and finish. Depends on rrss_pkg.
module rrss_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  rrss_pkg::seq_stat_t stat,
  output rrss_pkg::seq_ctrl_t ctrl
);

  rrss_pkg::state_t state;
  rrss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrss_pkg::ST_IDLE: begin
        if (start && req_type == rrss_pkg::REQ_SLICE && !stat.no_work) begin
          state_next = rrss_pkg::ST_READ;
        end
      end
      rrss_pkg::ST_READ: state_next = rrss_pkg::ST_SCAN;
      rrss_pkg::ST_SCAN: begin
        if (stat.rem_zero) begin
          state_next = rrss_pkg::ST_READ;
        end else begin
          state_next = rrss_pkg::ST_ADD;
        end
      end
      rrss_pkg::ST_ADD: state_next = rrss_pkg::ST_FIN;
      rrss_pkg::ST_FIN: state_next = rrss_pkg::ST_IDLE;
      default:          state_next = rrss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.alu_op  = rrss_pkg::ALU_SUB;
    ctrl.alu_sel = rrss_pkg::SEL_REM_QUANTUM;
    case (state)
      rrss_pkg::ST_IDLE: begin
        if (start) begin
          case (req_type)
            rrss_pkg::REQ_LOAD: begin
              ctrl.ld_ok   = !stat.full;
              ctrl.ld_full = stat.full;
            end
            rrss_pkg::REQ_CLEAR: ctrl.clr = 1'b1;
            rrss_pkg::REQ_SLICE: begin
              ctrl.slice_go = !stat.no_work;
              ctrl.nop      = stat.no_work;
            end
            default: ctrl.nop = 1'b1;
          endcase
        end
      end
      rrss_pkg::ST_READ: begin
        ctrl.busy = 1'b1;
        ctrl.rd   = 1'b1;
      end
      rrss_pkg::ST_SCAN: begin
        ctrl.busy  = 1'b1;
        ctrl.skip  = stat.rem_zero;
        ctrl.sub_q = !stat.rem_zero;
      end
      rrss_pkg::ST_ADD: begin
        ctrl.busy    = 1'b1;
        ctrl.add     = 1'b1;
        ctrl.alu_op  = rrss_pkg::ALU_ADD;
        ctrl.alu_sel = rrss_pkg::SEL_TIME_RUN;
      end
      rrss_pkg::ST_FIN: begin
        ctrl.busy    = 1'b1;
        ctrl.fin     = 1'b1;
        ctrl.alu_sel = rrss_pkg::SEL_TIME_ORIG;
      end
      default: ctrl.busy = 1'b0;
    endcase
  end

endmodule

/* hw/rtl/round_robin_slice_scheduler.sv */
// Top level of the round-robin slice scheduler: job counters, running time and result register.
// Depends on rrss_pkg, rrss_burst_ram, rrss_alu and rrss_seq.
//
// Usage. A transaction is taken when start is high and busy is low; req carries the request
// type and, for a load, the burst length. The user must write the quantum register through
// cfg_we and cfg_wdata only while idle, which the block does not check; a quantum of zero acts as one.
// Every transaction yields exactly one result: result_valid is high for one cycle and result
// holds the fields in that cycle. The receiver cannot stall, so nothing is ever held back.
// Load, clear, reserved and empty slice requests finish in the accepting cycle, and their
// result appears in the following cycle; busy stays low, so one may be taken every cycle.
// A slice request holds busy through read, scan, add and finish, repeating read and scan for each
// finished job the scan passes over; each burst store read spans address, then registered data.
// Its result appears in the first cycle of low busy, when a new transaction may already enter.
// The shared adder computes remainder minus quantum, then the new time, then the waiting time.
// Reset clears the batch, the time and the sequencer, and sets the quantum to four. The burst
// store has no reset; only entries that were loaded are ever read.
module round_robin_slice_scheduler #(
  parameter int MAX_JOBS = rrss_pkg::MAX_JOBS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rrss_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [rrss_pkg::BURST_W-1:0] cfg_wdata,
  output logic                         result_valid,
  output rrss_pkg::res_t               result
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int BW    = rrss_pkg::BURST_W;
  localparam int TW    = rrss_pkg::TIME_W;

  logic [BW-1:0]    quantum;
  logic [CNT_W-1:0] jobs_loaded;
  logic [CNT_W-1:0] jobs_loaded_next;
  logic [CNT_W-1:0] jobs_unfinished;
  logic [CNT_W-1:0] jobs_unfinished_next;
  logic [IDX_W-1:0] next_position;
  logic [TW-1:0]    current_time;
  logic [IDX_W-1:0] idx;
  logic [BW-1:0]    run;
  logic [BW-1:0]    new_rem;
  rrss_pkg::res_t   result_next;

  rrss_pkg::seq_stat_t stat;
  rrss_pkg::seq_ctrl_t ctrl;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [2*BW-1:0]  ram_wdata;
  logic [2*BW-1:0]  ram_rdata;
  logic [BW-1:0]    rd_orig;
  logic [BW-1:0]    rd_rem;

  logic [TW-1:0]    alu_a;
  logic [TW-1:0]    alu_b;
  logic [TW-1:0]    alu_res;
  logic             alu_borrow;
  logic [BW-1:0]    q_eff;

  logic [CNT_W-1:0] idx_inc;
  logic [IDX_W-1:0] idx_wrap;

  assign rd_orig = ram_rdata[2*BW-1:BW];
  assign rd_rem  = ram_rdata[BW-1:0];
  assign q_eff   = (quantum == '0) ? BW'(1) : quantum;

  assign idx_inc  = CNT_W'(idx) + CNT_W'(1);
  assign idx_wrap = (idx_inc == jobs_loaded) ? '0 : IDX_W'(idx_inc);

  assign stat.full     = (jobs_loaded == CNT_W'(MAX_JOBS));
  assign stat.no_work  = (jobs_unfinished == '0) || (jobs_loaded == '0);
  assign stat.rem_zero = (rd_rem == '0);

  assign busy = ctrl.busy;

  rrss_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  always_comb begin
    case (ctrl.alu_sel)
      rrss_pkg::SEL_REM_QUANTUM: begin
        alu_a = TW'(rd_rem);
        alu_b = TW'(q_eff);
      end
      rrss_pkg::SEL_TIME_RUN: begin
        alu_a = current_time;
        alu_b = TW'(run);
      end
      rrss_pkg::SEL_TIME_ORIG: begin
        alu_a = current_time;
        alu_b = TW'(rd_orig);
      end
      default: begin
        alu_a = current_time;
        alu_b = '0;
      end
    endcase
  end

  rrss_alu u_alu (
    .op     (ctrl.alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {rd_orig, new_rem};
    if (ctrl.ld_ok) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(jobs_loaded);
      ram_wdata = {req.burst, req.burst};
    end else if (ctrl.fin) begin
      ram_we = 1'b1;
    end
  end

  rrss_burst_ram #(
    .DEPTH (MAX_JOBS),
    .WIDTH (2 * BW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.rd),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    jobs_loaded_next     = jobs_loaded;
    jobs_unfinished_next = jobs_unfinished;
    if (ctrl.clr) begin
      jobs_loaded_next     = '0;
      jobs_unfinished_next = '0;
    end else if (ctrl.ld_ok) begin
      jobs_loaded_next = jobs_loaded + CNT_W'(1);
      if (req.burst != '0) begin
        jobs_unfinished_next = jobs_unfinished + CNT_W'(1);
      end
    end else if (ctrl.fin && new_rem == '0) begin
      jobs_unfinished_next = jobs_unfinished - CNT_W'(1);
    end
  end

  always_comb begin
    result_next          = '0;
    result_next.kind     = rrss_pkg::KIND_NONE;
    result_next.all_done = (jobs_unfinished_next == '0);
    if (ctrl.ld_ok) begin
      result_next.kind      = rrss_pkg::KIND_LOADED;
      result_next.job_index = rrss_pkg::JOB_IDX_W'(jobs_loaded);
    end else if (ctrl.ld_full) begin
      result_next.kind = rrss_pkg::KIND_FULL;
    end else if (ctrl.fin) begin
      result_next.kind           = rrss_pkg::KIND_SLICE;
      result_next.job_index      = rrss_pkg::JOB_IDX_W'(idx);
      result_next.slice_end_time = current_time;
      result_next.job_finished   = (new_rem == '0);
      result_next.waiting_time   = (new_rem == '0) ? alu_res : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum         <= rrss_pkg::QUANTUM_RST;
      jobs_loaded     <= '0;
      jobs_unfinished <= '0;
      next_position   <= '0;
      current_time    <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_wdata;
      end
      jobs_loaded     <= jobs_loaded_next;
      jobs_unfinished <= jobs_unfinished_next;
      if (ctrl.clr) begin
        next_position <= '0;
        current_time  <= '0;
      end else begin
        if (ctrl.fin) begin
          next_position <= idx_wrap;
        end
        if (ctrl.add) begin
          current_time <= alu_res;
        end
      end
      result_valid <= ctrl.ld_ok || ctrl.ld_full || ctrl.clr || ctrl.nop || ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.slice_go) begin
      idx <= next_position;
    end else if (ctrl.skip) begin
      idx <= idx_wrap;
    end
    if (ctrl.sub_q) begin
      if (alu_borrow) begin
        run     <= rd_rem;
        new_rem <= '0;
      end else begin
        run     <= q_eff;
        new_rem <= alu_res[BW-1:0];
      end
    end
    result <= result_next;
  end

`ifndef SYNTH
  a_result_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("A result was presented while a slice was still in progress.");

  a_unfinished_le_loaded: assert property (@(posedge clk) disable iff (rst)
    jobs_unfinished <= jobs_loaded)
    else $error("More unfinished jobs than loaded jobs.");

  a_position_in_batch: assert property (@(posedge clk) disable iff (rst)
    (jobs_loaded == '0 && next_position == '0) || (CNT_W'(next_position) < jobs_loaded))
    else $error("The next position lies outside the loaded batch.");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_valid || busy))
    else $error("An accepted transaction neither produced a result nor started a slice.");
`endif

endmodule
